@@ rtl/core/rsee_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsee_pkg
// Types and constants shared by the RPN sample expression evaluator.
// ----------------------------------------------------------------------------
package rsee_pkg;

    localparam int PROGRAM_DEPTH = 32;
    localparam int PROG_AW       = $clog2(PROGRAM_DEPTH);
    localparam int DEPTH_W       = $clog2(PROGRAM_DEPTH + 1);

    localparam logic [1:0] KIND_CONST = 2'd0;
    localparam logic [1:0] KIND_TIME  = 2'd1;
    localparam logic [1:0] KIND_OPER  = 2'd2;

    localparam logic [30:0] OP_SHL = 31'd0;
    localparam logic [30:0] OP_SHR = 31'd1;
    localparam logic [30:0] OP_XOR = 31'd2;
    localparam logic [30:0] OP_OR  = 31'd3;
    localparam logic [30:0] OP_AND = 31'd4;
    localparam logic [30:0] OP_ADD = 31'd5;
    localparam logic [30:0] OP_SUB = 31'd6;
    localparam logic [30:0] OP_MUL = 31'd7;
    localparam logic [30:0] OP_DIV = 31'd8;
    localparam logic [30:0] OP_MOD = 31'd9;
    localparam logic [30:0] OP_NOT = 31'd10;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [4:0]  token_index;
        logic [1:0]  token_kind;
        logic [30:0] token_value;
        logic [30:0] sample_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               stack_error;
    } t_out_item;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  index;
        logic [1:0]  kind;
        logic [30:0] value;
        logic [30:0] stime;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

endpackage
`default_nettype wire

@@ rtl/core/rsee_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/rsee_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsee_front
// Accepts items, classifies them into write/evaluate commands, 2-deep queue.
// ----------------------------------------------------------------------------
module rsee_front import rsee_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_in_item,
    output logic          o_full,
    output t_cmd_q        o_cmd,
    input  wire logic     i_take
);
    t_cmd       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;
    t_cmd       w_cmd;

    assign o_full = (r_count == 2'd2);
    assign w_push = i_push && !o_full;
    assign w_pop  = i_take && (r_count != 2'd0);

    always_comb begin
        w_cmd.cmd   = i_in_item.action ? CMD_EVAL : CMD_WRITE;
        w_cmd.index = i_in_item.token_index;
        w_cmd.kind  = i_in_item.token_kind;
        w_cmd.value = i_in_item.token_value;
        w_cmd.stime = i_in_item.sample_time;
    end

    assign o_cmd = {(r_count != 2'd0), r_slot[r_rd_ptr]};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/rsee_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsee_back
// Executes commands: program writes and stack-machine evaluation.
// ----------------------------------------------------------------------------
module rsee_back import rsee_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd_q     i_cmd,
    output logic            o_take,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata,
    output logic            o_empty,
    input  wire logic       i_pop,
    output t_out_item       o_out_item
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_TOKEN = 3'd2;
    localparam logic [2:0] S_OPRD  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [5:0]         r_prog_len;
    logic [DEPTH_W-1:0] r_idx, n_idx, r_depth, n_depth, w_len;
    logic [31:0]        r_tos, n_tos, r_time, n_time;
    logic               r_err, n_err;
    logic [30:0]        r_code, n_code;
    logic [31:0]        r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_neg_q, n_neg_q, r_neg_r, n_neg_r;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               w_prog_we, w_stk_we;
    logic [32:0]        w_prog_rdata;
    logic [31:0]        w_stk_rdata, w_stk_wdata, w_bin, w_a, w_b;
    logic [PROG_AW-1:0] w_stk_waddr;
    logic [1:0]         w_kind;
    logic [30:0]        w_val;
    logic [32:0]        w_rem_sh, w_diff;

    rsee_ram #(.WIDTH(33), .DEPTH(PROGRAM_DEPTH)) u_prog (
        .i_clk  (i_clk),
        .i_we   (w_prog_we),
        .i_waddr(PROG_AW'(i_cmd.cmd.index)),
        .i_wdata({i_cmd.cmd.kind, i_cmd.cmd.value}),
        .i_raddr(r_idx[PROG_AW-1:0]),
        .o_rdata(w_prog_rdata)
    );

    rsee_ram #(.WIDTH(32), .DEPTH(PROGRAM_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_stk_we),
        .i_waddr(w_stk_waddr),
        .i_wdata(w_stk_wdata),
        .i_raddr(PROG_AW'(r_depth - DEPTH_W'(2))),
        .o_rdata(w_stk_rdata)
    );

    assign w_kind      = w_prog_rdata[32:31];
    assign w_val       = w_prog_rdata[30:0];
    assign w_len       = (32'(r_prog_len) > PROGRAM_DEPTH) ? DEPTH_W'(PROGRAM_DEPTH)
                                                            : DEPTH_W'(r_prog_len);
    assign o_take      = (r_state == S_IDLE) && i_cmd.valid;
    assign w_prog_we   = o_take && (i_cmd.cmd.cmd == CMD_WRITE)
                         && (32'(i_cmd.cmd.index) < PROGRAM_DEPTH);
    assign w_stk_waddr = PROG_AW'(r_depth - DEPTH_W'(1));
    assign w_stk_wdata = r_tos;
    assign w_stk_we    = (r_state == S_TOKEN)
                         && (w_kind == KIND_CONST || w_kind == KIND_TIME)
                         && (32'(r_depth) < PROGRAM_DEPTH) && (r_depth != '0);

    assign w_a = w_stk_rdata;
    assign w_b = r_tos;
    always_comb begin
        case (r_code)
            OP_SHL:  w_bin = w_a << w_b[4:0];
            OP_SHR:  w_bin = 32'($signed(w_a) >>> w_b[4:0]);
            OP_XOR:  w_bin = w_a ^ w_b;
            OP_OR:   w_bin = w_a | w_b;
            OP_AND:  w_bin = w_a & w_b;
            OP_ADD:  w_bin = w_a + w_b;
            OP_SUB:  w_bin = w_a - w_b;
            OP_MUL:  w_bin = w_a * w_b;
            default: w_bin = 32'd0;
        endcase
    end

    // restoring divide step on magnitudes
    assign w_rem_sh = {r_rem, r_quo[31]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_depth     = r_depth;
        n_tos       = r_tos;
        n_time      = r_time;
        n_err       = r_err;
        n_code      = r_code;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_neg_q     = r_neg_q;
        n_neg_r     = r_neg_r;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (o_take && i_cmd.cmd.cmd == CMD_EVAL) begin
                    n_idx   = '0;
                    n_depth = '0;
                    n_err   = 1'b0;
                    n_time  = {1'b0, i_cmd.cmd.stime};
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = (r_idx == w_len) ? S_DONE : S_TOKEN;
            end
            S_TOKEN: begin
                n_idx   = r_idx + DEPTH_W'(1);
                n_state = S_FETCH;
                if (w_kind == KIND_CONST || w_kind == KIND_TIME) begin
                    if (32'(r_depth) >= PROGRAM_DEPTH) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_tos   = (w_kind == KIND_CONST) ? {1'b0, w_val} : r_time;
                        n_depth = r_depth + DEPTH_W'(1);
                    end
                end else if (w_kind == KIND_OPER) begin
                    if (w_val == OP_NOT) begin
                        if (r_depth == '0) begin
                            n_err   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_tos = ~r_tos;
                        end
                    end else if (r_depth < DEPTH_W'(2)) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_code  = w_val;
                        n_idx   = r_idx;
                        n_state = S_OPRD;
                    end
                end
            end
            S_OPRD: begin
                n_depth = r_depth - DEPTH_W'(1);
                n_idx   = r_idx + DEPTH_W'(1);
                n_state = S_FETCH;
                if ((r_code == OP_DIV || r_code == OP_MOD) && w_b == 32'd0) begin
                    n_tos = 32'd0;
                end else if (r_code == OP_DIV || r_code == OP_MOD) begin
                    n_depth = r_depth;
                    n_idx   = r_idx;
                    n_rem   = 32'd0;
                    n_quo   = w_a[31] ? -w_a : w_a;
                    n_dvs   = w_b[31] ? -w_b : w_b;
                    n_neg_q = w_a[31] ^ w_b[31];
                    n_neg_r = w_a[31];
                    n_cnt   = 5'd0;
                    n_state = S_DIV;
                end else begin
                    n_tos = w_bin;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (!w_diff[32]) begin
                    n_rem = w_diff[31:0];
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[31:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                if (r_cnt == 5'd31) begin
                    if (r_code == OP_DIV) begin
                        n_tos = r_neg_q ? -n_quo : n_quo;
                    end else begin
                        n_tos = r_neg_r ? -n_rem : n_rem;
                    end
                    n_depth = r_depth - DEPTH_W'(1);
                    n_idx   = r_idx + DEPTH_W'(1);
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    if (!r_err && r_depth == DEPTH_W'(1)) begin
                        n_out.sample_value = r_tos;
                        n_out.stack_error  = 1'b0;
                    end else begin
                        n_out.sample_value = 32'sd0;
                        n_out.stack_error  = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_tos   <= n_tos;
        r_time  <= n_time;
        r_err   <= n_err;
        r_code  <= n_code;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_cnt   <= n_cnt;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_prog_len  <= 6'd0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_prog_len <= i_cfg_wdata;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_item = r_out;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= PROGRAM_DEPTH)
        else $error("stack depth beyond capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out))
        else $error("waiting result lost or changed");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.stack_error |-> r_out.sample_value == 32'sd0)
        else $error("error result with nonzero value");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_state == S_IDLE)
        else $error("command taken while busy");
`endif
endmodule
`default_nettype wire

@@ rtl/core/rpn_sample_expression_evaluator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_sample_expression_evaluator_top
// RPN token program store and 32-bit stack evaluator for sample synthesis.
// ----------------------------------------------------------------------------
// Channel  | Ports                            | Transfer when
// input    | i_push, o_full, i_in_item        | i_push && !o_full
// result   | o_empty, i_pop, o_out_item       | i_pop && !o_empty
// config   | i_cfg_we, i_cfg_wdata            | i_cfg_we (program_length)
//
// The back end takes a write item or an evaluation only while idle. An
// evaluation fetches its tokens serially, and each div/mod with a nonzero
// divisor runs through the bit-serial divider. Reset is synchronous, active
// low; program and stack RAMs hold no reset. A 2-entry input queue and a
// result register let each side stall on its own; a finished result waits
// in the register until popped.
// ----------------------------------------------------------------------------
module rpn_sample_expression_evaluator_top import rsee_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_in_item   i_in_item,
    output logic            o_full,
    output logic            o_empty,
    input  wire logic       i_pop,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata
);
    t_cmd_q w_cmd;   // front queue head toward the execution side
    logic   w_take;  // back end consumes the head this cycle

    rsee_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_in_item(i_in_item),
        .o_full   (o_full),
        .o_cmd    (w_cmd),
        .i_take   (w_take)
    );

    // program writes and evaluations run in arrival order in the back end
    rsee_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_take     (w_take),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out_item (o_out_item)
    );
endmodule
`default_nettype wire
